// ===== rtl/prac_pkg.sv =====
package prac_pkg;

  localparam int CW   = 16;
  localparam int AW   = 16;
  localparam int DW   = CW + 1;
  localparam int QW   = 32;
  localparam int FRAC = 30;
  localparam int PW   = DW + QW;
  localparam int SW   = PW + 1;
  localparam int MW   = SW - FRAC;
  localparam int RW   = MW + 2;

  localparam logic signed [QW-1:0] CORDIC_GAIN = 32'sh26DD_3B6A;
  localparam logic signed [QW-1:0] Q_ONE       = 32'sh4000_0000;
  localparam logic [QW-1:0]        EIGHTH_TURN = 32'h2000_0000;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic [AW-1:0]        angle_turns;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0] rotated_x;
    logic signed [CW-1:0] rotated_y;
    logic                 saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
    quad_t                quad;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
  } cordic_t;

  // atan(2^-i), 2^32 units per turn
  function automatic logic [QW-1:0] atan_turns(input int idx);
    logic [QW-1:0] a;
    case (idx)
      0:  a = 32'h2000_0000;
      1:  a = 32'h12E4_051D;
      2:  a = 32'h09FB_385B;
      3:  a = 32'h0511_11D4;
      4:  a = 32'h028B_0D43;
      5:  a = 32'h0145_D7E1;
      6:  a = 32'h00A2_F61E;
      7:  a = 32'h0051_7C55;
      8:  a = 32'h0028_BE53;
      9:  a = 32'h0014_5F2E;
      10: a = 32'h000A_2F98;
      11: a = 32'h0005_17CC;
      12: a = 32'h0002_8BE6;
      13: a = 32'h0001_45F3;
      14: a = 32'h0000_A2F9;
      15: a = 32'h0000_517C;
      16: a = 32'h0000_28BE;
      17: a = 32'h0000_145F;
      18: a = 32'h0000_0A2F;
      19: a = 32'h0000_0517;
      20: a = 32'h0000_028B;
      21: a = 32'h0000_0145;
      22: a = 32'h0000_00A2;
      23: a = 32'h0000_0051;
      24: a = 32'h0000_0028;
      25: a = 32'h0000_0014;
      26: a = 32'h0000_000A;
      27: a = 32'h0000_0005;
      28: a = 32'h0000_0002;
      29: a = 32'h0000_0001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/point_rotate_about_center.sv =====
// Rotates a point about a center by a binary-fraction angle.
// Input channel: in_valid / in_ready / in_item (point, center, angle).
// Result channel: out_valid / out_ready / out_item (rotated point, clip flag).
// An item is taken on any edge where valid and ready are both high.
// Path from input to output, each step registered:
//   one angle-reduction stage, one CORDIC stage per iteration, then
//   quadrant fold, products, sums, rounding and a saturating output register.
// Throughput: one item per cycle while out_ready is high; every stage is its
// own register and the multiply stage runs four parallel 17x32 multipliers.
// Stalls: each stage holds its item while the next is full; bubbles close up,
// so in_ready stays high while any stage ahead has room, even with a
// finished result waiting at the output.
// Reset: synchronous, active low; empties all stages, out_valid goes low.
module point_rotate_about_center #(
  parameter int ROTATION_STEPS = 18
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  prac_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output prac_pkg::out_item_t out_item
);
  import prac_pkg::*;

  cordic_t                 cd [ROTATION_STEPS+1];
  logic [ROTATION_STEPS:0] cv;
  logic [ROTATION_STEPS:0] cr;

  prac_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_item),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_data  (cd[0])
  );

  for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_step
    prac_cordic_step #(
      .IDX (i)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .in_data   (cd[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .out_data  (cd[i+1])
    );
  end

  prac_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cv[ROTATION_STEPS]),
    .in_ready  (cr[ROTATION_STEPS]),
    .in_data   (cd[ROTATION_STEPS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_item)
  );

`ifndef SYNTH
  localparam logic signed [CW-1:0] A_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] A_MIN = {1'b1, {(CW-1){1'b0}}};

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.saturated |->
      (out_item.rotated_x == A_MAX || out_item.rotated_x == A_MIN ||
       out_item.rotated_y == A_MAX || out_item.rotated_y == A_MIN))
    else $error("clip flag set with no coordinate at a bound");
`endif

endmodule

// ===== rtl/prac_prep.sv =====
module prac_prep (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  prac_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output prac_pkg::cordic_t   out_data
);
  import prac_pkg::*;

  logic          valid_r;
  cordic_t       data_r;
  cordic_t       data_nxt;
  logic [QW-1:0] theta;
  logic [QW-1:0] theta_off;
  logic [1:0]    quad;
  logic [QW-1:0] resid;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    theta     = {in_data.angle_turns, {(QW-AW){1'b0}}};
    theta_off = theta + EIGHTH_TURN;
    quad      = theta_off[QW-1:QW-2];
    resid     = theta - {quad, {(QW-2){1'b0}}};
    data_nxt.x    = CORDIC_GAIN;
    data_nxt.y    = '0;
    data_nxt.z    = signed'(resid);
    data_nxt.quad = quad_t'(quad);
    data_nxt.dx   = {in_data.point_x[CW-1], in_data.point_x}
                  - {in_data.center_x[CW-1], in_data.center_x};
    data_nxt.dy   = {in_data.point_y[CW-1], in_data.point_y}
                  - {in_data.center_y[CW-1], in_data.center_y};
    data_nxt.cx   = in_data.center_x;
    data_nxt.cy   = in_data.center_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/prac_cordic_step.sv =====
module prac_cordic_step #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  prac_pkg::cordic_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output prac_pkg::cordic_t  out_data
);
  import prac_pkg::*;

  localparam logic signed [QW-1:0] ATAN = signed'(atan_turns(IDX));

  logic                 valid_r;
  cordic_t              data_r;
  cordic_t              data_nxt;
  logic signed [QW-1:0] xs;
  logic signed [QW-1:0] ys;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    xs       = in_data.x >>> IDX;
    ys       = in_data.y >>> IDX;
    data_nxt = in_data;
    if (!in_data.z[QW-1]) begin
      data_nxt.x = in_data.x - ys;
      data_nxt.y = in_data.y + xs;
      data_nxt.z = in_data.z - ATAN;
    end else begin
      data_nxt.x = in_data.x + ys;
      data_nxt.y = in_data.y - xs;
      data_nxt.z = in_data.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/prac_mac.sv =====
module prac_mac (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  prac_pkg::cordic_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output prac_pkg::out_item_t out_data
);
  import prac_pkg::*;

  localparam int NS = 5;
  localparam logic signed [SW-1:0] RND_HALF = {{(SW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
  localparam logic signed [RW-1:0] C_MAX = RW'((2**(CW-1)) - 1);
  localparam logic signed [RW-1:0] C_MIN = -C_MAX - RW'(1);

  typedef struct packed {
    logic signed [QW-1:0] c;
    logic signed [QW-1:0] s;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
  } trig_t;

  typedef struct packed {
    logic signed [PW-1:0] pxc;
    logic signed [PW-1:0] pys;
    logic signed [PW-1:0] pxs;
    logic signed [PW-1:0] pyc;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
  } prod_t;

  typedef struct packed {
    logic signed [SW-1:0] vx;
    logic signed [SW-1:0] vy;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
  } sum_t;

  typedef struct packed {
    logic [MW-1:0]        mx;
    logic [MW-1:0]        my;
    logic                 nx;
    logic                 ny;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
  } mag_t;

  logic [NS-1:0] vld_r;
  logic [NS:0]   rdy;
  logic [NS-1:0] vin;

  trig_t     trig_r, trig_nxt;
  prod_t     prod_r, prod_nxt;
  sum_t      sum_r, sum_nxt;
  mag_t      mag_r, mag_nxt;
  out_item_t res_r, res_nxt;

  logic signed [QW-1:0] c_raw, s_raw;
  logic signed [SW-1:0] ax, ay;
  logic signed [RW-1:0] rx, ry;
  logic [CW:0]          sx, sy;

  function automatic logic [CW:0] sat(input logic signed [RW-1:0] v);
    logic [CW:0] r;
    if (v > C_MAX) begin
      r = {1'b1, C_MAX[CW-1:0]};
    end else if (v < C_MIN) begin
      r = {1'b1, C_MIN[CW-1:0]};
    end else begin
      r = {1'b0, v[CW-1:0]};
    end
    return r;
  endfunction

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NS-1];
  assign out_data  = res_r;

  always_comb begin
    rdy[NS] = out_ready;
    vin[0]  = in_valid;
    for (int k = 1; k < NS; k++) begin
      vin[k] = vld_r[k-1];
    end
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  // quadrant fold and clamp
  always_comb begin
    case (in_data.quad)
      QUAD_0: begin
        c_raw = in_data.x;
        s_raw = in_data.y;
      end
      QUAD_1: begin
        c_raw = -in_data.y;
        s_raw = in_data.x;
      end
      QUAD_2: begin
        c_raw = -in_data.x;
        s_raw = -in_data.y;
      end
      QUAD_3: begin
        c_raw = in_data.y;
        s_raw = -in_data.x;
      end
      default: begin
        c_raw = in_data.x;
        s_raw = in_data.y;
      end
    endcase
    trig_nxt.c  = (c_raw > Q_ONE) ? Q_ONE : ((c_raw < -Q_ONE) ? -Q_ONE : c_raw);
    trig_nxt.s  = (s_raw > Q_ONE) ? Q_ONE : ((s_raw < -Q_ONE) ? -Q_ONE : s_raw);
    trig_nxt.dx = in_data.dx;
    trig_nxt.dy = in_data.dy;
    trig_nxt.cx = in_data.cx;
    trig_nxt.cy = in_data.cy;
  end

  always_comb begin
    prod_nxt.pxc = PW'(trig_r.dx) * PW'(trig_r.c);
    prod_nxt.pys = PW'(trig_r.dy) * PW'(trig_r.s);
    prod_nxt.pxs = PW'(trig_r.dx) * PW'(trig_r.s);
    prod_nxt.pyc = PW'(trig_r.dy) * PW'(trig_r.c);
    prod_nxt.cx  = trig_r.cx;
    prod_nxt.cy  = trig_r.cy;
  end

  always_comb begin
    sum_nxt.vx = SW'(prod_r.pxc) - SW'(prod_r.pys);
    sum_nxt.vy = SW'(prod_r.pxs) + SW'(prod_r.pyc);
    sum_nxt.cx = prod_r.cx;
    sum_nxt.cy = prod_r.cy;
  end

  // round half away from zero on the magnitude
  always_comb begin
    ax = sum_r.vx[SW-1] ? (RND_HALF - sum_r.vx) : (sum_r.vx + RND_HALF);
    ay = sum_r.vy[SW-1] ? (RND_HALF - sum_r.vy) : (sum_r.vy + RND_HALF);
    mag_nxt.mx = ax[SW-1:FRAC];
    mag_nxt.my = ay[SW-1:FRAC];
    mag_nxt.nx = sum_r.vx[SW-1];
    mag_nxt.ny = sum_r.vy[SW-1];
    mag_nxt.cx = sum_r.cx;
    mag_nxt.cy = sum_r.cy;
  end

  always_comb begin
    rx = mag_r.nx ? ({{(RW-CW){mag_r.cx[CW-1]}}, mag_r.cx} - {2'b00, mag_r.mx})
                  : ({{(RW-CW){mag_r.cx[CW-1]}}, mag_r.cx} + {2'b00, mag_r.mx});
    ry = mag_r.ny ? ({{(RW-CW){mag_r.cy[CW-1]}}, mag_r.cy} - {2'b00, mag_r.my})
                  : ({{(RW-CW){mag_r.cy[CW-1]}}, mag_r.cy} + {2'b00, mag_r.my});
    sx = sat(rx);
    sy = sat(ry);
    res_nxt.rotated_x = sx[CW-1:0];
    res_nxt.rotated_y = sy[CW-1:0];
    res_nxt.saturated = sx[CW] | sy[CW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vin[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && vin[0]) begin
      trig_r <= trig_nxt;
    end
    if (rdy[1] && vin[1]) begin
      prod_r <= prod_nxt;
    end
    if (rdy[2] && vin[2]) begin
      sum_r <= sum_nxt;
    end
    if (rdy[3] && vin[3]) begin
      mag_r <= mag_nxt;
    end
    if (rdy[4] && vin[4]) begin
      res_r <= res_nxt;
    end
  end

endmodule
